FILE: src/vdi_pkg.sv
// Shared constants, codes and control types of the Verlet drag integrator.
package vdi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [1:0] REG_GRAVITY   = 2'd0;
	localparam logic [1:0] REG_MASS      = 2'd1;
	localparam logic [1:0] REG_DRAG_COEF = 2'd2;
	localparam logic [1:0] REG_TIME_STEP = 2'd3;

	localparam logic signed [31:0] GRAVITY_RST   = 32'sd655360;
	localparam logic [30:0]        MASS_RST      = 31'd5242880;
	localparam logic signed [31:0] DRAG_COEF_RST = -32'sd20972;
	localparam logic [30:0]        TIME_STEP_RST = 31'd19661;

	localparam logic [1:0] ALU_MULQ = 2'd0;
	localparam logic [1:0] ALU_MULX = 2'd1;
	localparam logic [1:0] ALU_DIVQ = 2'd2;
	localparam logic [1:0] ALU_SQRT = 2'd3;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

endpackage

FILE: src/vdi_if.sv
// Handshake channels of the Verlet drag integrator: input items, results, register writes.
interface vdi_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] init_pos_x;
	logic signed [31:0] init_pos_y;
	logic signed [31:0] init_pos_z;
	logic signed [31:0] init_vel_x;
	logic signed [31:0] init_vel_y;
	logic signed [31:0] init_vel_z;
	modport source(output valid, opcode, init_pos_x, init_pos_y, init_pos_z,
		init_vel_x, init_vel_y, init_vel_z, input ready);
	modport sink(input valid, opcode, init_pos_x, init_pos_y, init_pos_z,
		init_vel_x, init_vel_y, init_vel_z, output ready);
endinterface

interface vdi_rsp_if;
	logic               valid;
	logic               ready;
	logic [30:0]        sim_time;
	logic signed [31:0] out_pos_x;
	logic signed [31:0] out_pos_y;
	logic signed [31:0] out_pos_z;
	logic signed [31:0] out_vel_x;
	logic signed [31:0] out_vel_y;
	logic signed [31:0] out_vel_z;
	logic signed [31:0] out_acc_x;
	logic signed [31:0] out_acc_y;
	logic signed [31:0] out_acc_z;
	modport source(output valid, sim_time, out_pos_x, out_pos_y, out_pos_z,
		out_vel_x, out_vel_y, out_vel_z, out_acc_x, out_acc_y, out_acc_z, input ready);
	modport sink(input valid, sim_time, out_pos_x, out_pos_y, out_pos_z,
		out_vel_x, out_vel_y, out_vel_z, out_acc_x, out_acc_y, out_acc_z, output ready);
endinterface

interface vdi_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/vdi_alu.sv
// Shared bit-serial unit: rounded and exact multiply, fixed-point divide, square root.
module vdi_alu #(
	parameter int W = vdi_pkg::WORD_BITS_DEF,
	parameter int F = vdi_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vdi_pkg::alu_ctl_t   ctl,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	input  logic [2*W-1:0]      rad,
	output vdi_pkg::alu_sts_t   sts,
	output logic signed [W-1:0] res,
	output logic [2*W-1:0]      prod
);

	localparam int CW = $clog2(2*W+1);
	localparam int NW = 2*W+1;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic signed [W-1:0] from_mag(input logic [NW-1:0] m, input logic neg);
		logic [NW-1:0] lim;
		logic [NW-1:0] nm;
		lim = NW'(1) << (W-1);
		nm = ~m + 1'b1;
		if (neg)
			return (m > lim) ? {1'b1, {(W-1){1'b0}}} : nm[W-1:0];
		return (m >= lim) ? {1'b0, {(W-1){1'b1}}} : m[W-1:0];
	endfunction

	logic [1:0]          op_q;
	logic                neg_q;
	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [2*W-1:0]      acc_q;
	logic [W+1:0]        rem_q;
	logic [W-1:0]        dv_q;
	logic signed [W-1:0] res_q;

	logic [W-1:0]  ma, mb;
	logic [W:0]    msum;
	logic [W+1:0]  dtrial;
	logic [W+3:0]  r4, strial;
	logic [NW-1:0] rnd;

	always_comb begin
		ma = mag(a);
		mb = mag(b);
		msum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, dv_q} : {(W+1){1'b0}});
		dtrial = {1'b0, rem_q[W-1:0], acc_q[W+F-1]} - {2'b00, dv_q};
		r4 = {rem_q, acc_q[2*W-1:2*W-2]};
		strial = r4 - {2'b00, dv_q, 2'b01};
		rnd = {1'b0, acc_q} + (NW'(1) << (F-1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= vdi_pkg::ALU_MULQ;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				op_q  <= ctl.op;
				neg_q <= a[W-1] ^ b[W-1];
				rem_q <= '0;
				unique case (ctl.op)
					vdi_pkg::ALU_MULQ, vdi_pkg::ALU_MULX: begin
						acc_q  <= {{W{1'b0}}, mb};
						dv_q   <= ma;
						cnt_q  <= CW'(W);
						busy_q <= 1'b1;
					end
					vdi_pkg::ALU_DIVQ: begin
						acc_q <= {{(W-F){1'b0}}, ma, {F{1'b0}}};
						dv_q  <= mb;
						cnt_q <= CW'(W+F);
						if (b == '0) begin
							// divide by zero: clamp by the numerator's sign, zero for a zero numerator
							res_q  <= (a == '0) ? '0 :
								(a[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
							done_q <= 1'b1;
						end else begin
							busy_q <= 1'b1;
						end
					end
					vdi_pkg::ALU_SQRT: begin
						acc_q  <= rad;
						dv_q   <= '0;
						cnt_q  <= CW'(W);
						busy_q <= 1'b1;
					end
				endcase
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				unique case (op_q)
					vdi_pkg::ALU_MULQ, vdi_pkg::ALU_MULX: begin
						acc_q <= {msum, acc_q[W-1:1]};
					end
					vdi_pkg::ALU_DIVQ: begin
						if (!dtrial[W+1]) begin
							rem_q <= {1'b0, dtrial[W:0]};
							acc_q <= {acc_q[2*W-2:0], 1'b1};
						end else begin
							rem_q <= {1'b0, rem_q[W-1:0], acc_q[W+F-1]};
							acc_q <= {acc_q[2*W-2:0], 1'b0};
						end
					end
					vdi_pkg::ALU_SQRT: begin
						acc_q <= {acc_q[2*W-3:0], 2'b00};
						if (!strial[W+3]) begin
							rem_q <= strial[W+1:0];
							dv_q  <= {dv_q[W-2:0], 1'b1};
						end else begin
							rem_q <= r4[W+1:0];
							dv_q  <= {dv_q[W-2:0], 1'b0};
						end
					end
				endcase
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				unique case (op_q)
					vdi_pkg::ALU_MULQ: res_q <= from_mag(rnd >> F, neg_q);
					vdi_pkg::ALU_MULX: res_q <= '0;
					vdi_pkg::ALU_DIVQ: res_q <= from_mag(NW'(acc_q[W+F-1:0]), neg_q);
					vdi_pkg::ALU_SQRT: res_q <= from_mag(NW'(dv_q), 1'b0);
				endcase
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res = res_q;
	assign prod = acc_q;

endmodule

FILE: src/verlet_drag_integrator.sv
// Top level of the Verlet drag integrator: registers, sequencer and result register.
// One point mass under gravity and quadratic drag, position Verlet, signed fixed point
// (default Q16.16), every result saturating. A start item (opcode 0) loads p0, v0 and
// reports p0, v0 and the acceleration; a tick item (opcode 1) advances one step. All
// multiplies, divides and square roots run through one bit-serial unit, one bit per
// cycle; additions and saturation are done beside it.
// The block takes no new item until the current one is finished; a finished result
// waits in the output register while the next item runs. Registers may be written
// whenever the block is idle.
module verlet_drag_integrator #(
	parameter int FRAC_BITS = vdi_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = vdi_pkg::WORD_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	vdi_req_if.sink   req,
	vdi_rsp_if.source rsp,
	vdi_cfg_if.sink   cfg
);

	localparam int W  = WORD_BITS;
	localparam int XW = ((W > 32) ? W : 32) + 1;
	localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
	localparam logic signed [XW-1:0] OMAX_X = {{(XW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [XW-1:0] OMIN_X = ~OMAX_X;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DT2  = 4'd1;
	localparam logic [3:0] ST_POS  = 4'd2;
	localparam logic [3:0] ST_VEL  = 4'd3;
	localparam logic [3:0] ST_SQ   = 4'd4;
	localparam logic [3:0] ST_NORM = 4'd5;
	localparam logic [3:0] ST_K    = 4'd6;
	localparam logic [3:0] ST_FG   = 4'd7;
	localparam logic [3:0] ST_KV   = 4'd8;
	localparam logic [3:0] ST_ACC  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
		if (v > WMAX_X) return WMAX_X[W-1:0];
		if (v < WMIN_X) return WMIN_X[W-1:0];
		return v[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_s32(input logic signed [31:0] v);
		return sat_x({{(XW-32){v[31]}}, v});
	endfunction

	function automatic logic signed [W-1:0] sat_u31(input logic [30:0] v);
		return sat_x({{(XW-31){1'b0}}, v});
	endfunction

	function automatic logic signed [31:0] out32(input logic signed [W-1:0] w);
		logic signed [XW-1:0] x;
		x = {{(XW-W){w[W-1]}}, w};
		if (x > OMAX_X) return OMAX_X[31:0];
		if (x < OMIN_X) return OMIN_X[31:0];
		return x[31:0];
	endfunction

	function automatic logic signed [W-1:0] addsat(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y, input logic sub);
		logic [W:0] s;
		s = sub ? ({x[W-1], x} - {y[W-1], y}) : ({x[W-1], x} + {y[W-1], y});
		if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		return s[W-1:0];
	endfunction

	logic signed [31:0] grav_q;
	logic [30:0]        mass_q;
	logic signed [31:0] coef_q;
	logic [30:0]        tstep_q;

	logic [3:0]          state_q;
	logic                go_q;
	logic [1:0]          ax_q;
	logic                opcode_q;
	logic [30:0]         el_q;
	logic signed [W-1:0] prev_q [3];
	logic signed [W-1:0] cur_q [3];
	logic signed [W-1:0] acc_q [3];
	logic signed [W-1:0] vel_q [3];
	logic signed [W-1:0] dt2_q, norm_q, k_q, fgy_q, tmp_q;
	logic [2*W-1:0]      sumsq_q;
	logic                out_valid_q;
	logic [30:0]         o_time_q;
	logic signed [31:0]  o_pos_q [3];
	logic signed [31:0]  o_vel_q [3];
	logic signed [31:0]  o_acc_q [3];

	vdi_pkg::alu_ctl_t   alu_ctl;
	vdi_pkg::alu_sts_t   alu_sts;
	logic signed [W-1:0] alu_a, alu_b, alu_res;
	logic [2*W-1:0]      alu_prod;

	logic signed [W-1:0] dt_w, m_w, coef_w, grav_w, neg_m, pnew;
	logic [31:0]         el_sum;
	logic                compute;
	logic                last_ax;

	always_comb begin
		dt_w   = sat_u31(tstep_q);
		m_w    = sat_u31(mass_q);
		coef_w = sat_s32(coef_q);
		grav_w = sat_s32(grav_q);
		neg_m  = addsat('0, m_w, 1'b1);
		pnew   = addsat(addsat(addsat(cur_q[ax_q], cur_q[ax_q], 1'b0), prev_q[ax_q], 1'b1),
			alu_res, 1'b0);
		el_sum = {1'b0, el_q} + {1'b0, tstep_q};
		compute = (state_q != ST_IDLE) && (state_q != ST_DONE);
		last_ax = (ax_q == 2'd2);
	end

	always_comb begin
		alu_ctl.start = compute && !go_q;
		alu_ctl.op = vdi_pkg::ALU_MULQ;
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			ST_DT2: begin
				alu_a = dt_w;
				alu_b = dt_w;
			end
			ST_POS: begin
				alu_a = (opcode_q == vdi_pkg::OP_START) ? vel_q[ax_q] : dt2_q;
				alu_b = (opcode_q == vdi_pkg::OP_START) ? dt_w : acc_q[ax_q];
			end
			ST_VEL: begin
				alu_ctl.op = vdi_pkg::ALU_DIVQ;
				alu_a = addsat(cur_q[ax_q], prev_q[ax_q], 1'b1);
				alu_b = dt_w;
			end
			ST_SQ: begin
				alu_ctl.op = vdi_pkg::ALU_MULX;
				alu_a = vel_q[ax_q];
				alu_b = vel_q[ax_q];
			end
			ST_NORM: alu_ctl.op = vdi_pkg::ALU_SQRT;
			ST_K: begin
				alu_a = coef_w;
				alu_b = norm_q;
			end
			ST_FG: begin
				alu_a = neg_m;
				alu_b = grav_w;
			end
			ST_KV: begin
				alu_a = k_q;
				alu_b = vel_q[ax_q];
			end
			ST_ACC: begin
				alu_ctl.op = vdi_pkg::ALU_DIVQ;
				alu_a = tmp_q;
				alu_b = m_w;
			end
			default: ;
		endcase
	end

	vdi_alu #(.W(W), .F(FRAC_BITS)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (alu_a),
		.b      (alu_b),
		.rad    (sumsq_q),
		.sts    (alu_sts),
		.res    (alu_res),
		.prod   (alu_prod)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q  <= vdi_pkg::GRAVITY_RST;
			mass_q  <= vdi_pkg::MASS_RST;
			coef_q  <= vdi_pkg::DRAG_COEF_RST;
			tstep_q <= vdi_pkg::TIME_STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				vdi_pkg::REG_GRAVITY:   grav_q  <= cfg.data;
				vdi_pkg::REG_MASS:      mass_q  <= cfg.data[30:0];
				vdi_pkg::REG_DRAG_COEF: coef_q  <= cfg.data;
				vdi_pkg::REG_TIME_STEP: tstep_q <= cfg.data[30:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			ax_q        <= 2'd0;
			opcode_q    <= vdi_pkg::OP_START;
			el_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
				cur_q[i]  <= '0;
				acc_q[i]  <= '0;
			end
		end else begin
			if (alu_ctl.start) go_q <= 1'b1;
			if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						opcode_q <= req.opcode;
						ax_q     <= 2'd0;
						sumsq_q  <= '0;
						if (req.opcode == vdi_pkg::OP_START) begin
							el_q      <= '0;
							prev_q[0] <= sat_s32(req.init_pos_x);
							prev_q[1] <= sat_s32(req.init_pos_y);
							prev_q[2] <= sat_s32(req.init_pos_z);
							vel_q[0]  <= sat_s32(req.init_vel_x);
							vel_q[1]  <= sat_s32(req.init_vel_y);
							vel_q[2]  <= sat_s32(req.init_vel_z);
							state_q   <= ST_POS;
						end else begin
							el_q    <= el_sum[31] ? {31{1'b1}} : el_sum[30:0];
							state_q <= ST_DT2;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						o_time_q    <= el_q;
						for (int i = 0; i < 3; i++) begin
							o_pos_q[i] <= out32((opcode_q == vdi_pkg::OP_START) ?
								prev_q[i] : cur_q[i]);
							o_vel_q[i] <= out32(vel_q[i]);
							o_acc_q[i] <= out32(acc_q[i]);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (alu_sts.done) begin
						go_q <= 1'b0;
						unique case (state_q)
							ST_DT2: begin
								dt2_q   <= alu_res;
								state_q <= ST_POS;
							end
							ST_POS: begin
								if (opcode_q == vdi_pkg::OP_START) begin
									cur_q[ax_q] <= addsat(prev_q[ax_q], alu_res, 1'b0);
									ax_q        <= last_ax ? 2'd0 : ax_q + 2'd1;
									state_q     <= last_ax ? ST_SQ : ST_POS;
								end else begin
									prev_q[ax_q] <= cur_q[ax_q];
									cur_q[ax_q]  <= pnew;
									state_q      <= ST_VEL;
								end
							end
							ST_VEL: begin
								vel_q[ax_q] <= alu_res;
								ax_q        <= last_ax ? 2'd0 : ax_q + 2'd1;
								state_q     <= last_ax ? ST_SQ : ST_POS;
							end
							ST_SQ: begin
								sumsq_q <= sumsq_q + alu_prod;
								ax_q    <= last_ax ? 2'd0 : ax_q + 2'd1;
								state_q <= last_ax ? ST_NORM : ST_SQ;
							end
							ST_NORM: begin
								norm_q  <= alu_res;
								state_q <= ST_K;
							end
							ST_K: begin
								k_q     <= alu_res;
								state_q <= ST_FG;
							end
							ST_FG: begin
								fgy_q   <= alu_res;
								state_q <= ST_KV;
							end
							ST_KV: begin
								// gravity only acts on y
								tmp_q   <= (ax_q == 2'd1) ? addsat(fgy_q, alu_res, 1'b0) : alu_res;
								state_q <= ST_ACC;
							end
							ST_ACC: begin
								acc_q[ax_q] <= alu_res;
								ax_q        <= last_ax ? 2'd0 : ax_q + 2'd1;
								state_q     <= last_ax ? ST_DONE : ST_KV;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.sim_time  = o_time_q;
	assign rsp.out_pos_x = o_pos_q[0];
	assign rsp.out_pos_y = o_pos_q[1];
	assign rsp.out_pos_z = o_pos_q[2];
	assign rsp.out_vel_x = o_vel_q[0];
	assign rsp.out_vel_y = o_vel_q[1];
	assign rsp.out_vel_z = o_vel_q[2];
	assign rsp.out_acc_x = o_acc_q[0];
	assign rsp.out_acc_y = o_acc_q[1];
	assign rsp.out_acc_z = o_acc_q[2];

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.done |-> compute)
		else $error("arithmetic unit finished with no step in progress");
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		alu_ctl.start |-> !alu_sts.busy)
		else $error("arithmetic unit started while busy");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result presented outside the finish step");
	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q != ST_IDLE)
		else $error("accepted item did not start the sequencer");
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		compute |-> ax_q != 2'd3)
		else $error("axis counter out of range");
`endif

endmodule
